@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files of the stepper controller.
// Each macro expands to one labelled concurrent assertion, reset masked.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stepper check failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define STP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stepper check failed: next-cycle implication");

`endif

@@ rtl/stp_pkg.sv @@
// Shared types, constants and codes for the stepper position controller.
// No dependencies; every other file but assert_macros.svh imports this package.
package stp_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int TIME_BITS_DEF       = 32;

  localparam int ANGLE_W    = 32;
  localparam int TIME_IN_W  = 32;
  localparam int COUNT_W    = 32;
  localparam int VEL_W      = 25;
  localparam int SPR_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Shared multiplier: signed operands wide enough for 32-bit unsigned values.
  localparam int MUL_W   = 34;
  localparam int MUL_P_W = 2 * MUL_W;

  // Error and raw velocity widths.
  localparam int ERR_W = COUNT_W + 1;
  localparam int VF_W  = 50;

  // 2*pi taken as TWO_PI_NUM / TWO_PI_DEN.
  localparam logic [19:0] TWO_PI_NUM     = 20'd314159;
  localparam logic [15:0] TWO_PI_DEN     = 16'd50000;
  localparam int          DIV_REM_W      = 19;
  localparam int          DIV_STEP_BITS  = 4;
  localparam logic [31:0] STEP_THRESHOLD = 32'd256000000;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = 32'sh8000_0000;

  localparam logic [SPR_W-1:0]         SPR_RESET   = 16'd200;
  localparam logic [GAIN_W-1:0]        GAIN_RESET  = 16'd256;
  localparam logic signed [LIM_W-1:0]  UPPER_RESET = 17'sd1000;
  localparam logic signed [LIM_W-1:0]  LOWER_RESET = -17'sd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEPS_PER_REV = 2'd0,
    REG_GAIN          = 2'd1,
    REG_VEL_UPPER     = 2'd2,
    REG_VEL_LOWER     = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_K,
    ST_MUL_NUM,
    ST_DIV,
    ST_ERR,
    ST_MUL_VEL,
    ST_CLAMP,
    ST_MUL_TIME,
    ST_COMMIT
  } state_t;

  typedef enum logic [1:0] {
    MUL_K,
    MUL_NUM,
    MUL_VEL,
    MUL_TIME
  } mul_sel_t;

  typedef struct packed {
    logic [SPR_W-1:0]        steps_per_rev;
    logic [GAIN_W-1:0]       gain;
    logic signed [LIM_W-1:0] vel_upper;
    logic signed [LIM_W-1:0] vel_lower;
  } cfg_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_load;
    logic     div_step;
    logic     err_en;
    logic     clamp_en;
    logic     commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_stat_t;

endpackage

@@ rtl/stp_if.sv @@
// Valid/ready channel interfaces of the stepper controller: input, result
// and configuration write. Depends on stp_pkg for field widths.
interface stp_in_if;
  import stp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] target_angle;
  logic [TIME_IN_W-1:0]      now_us;
  modport source (output valid, output target_angle, output now_us, input ready);
  modport sink   (input valid, input target_angle, input now_us, output ready);
endinterface

interface stp_out_if;
  import stp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      step_pulse;
  logic                      direction;
  logic signed [COUNT_W-1:0] step_count;
  logic signed [VEL_W-1:0]   velocity;
  modport source (output valid, output step_pulse, output direction,
                  output step_count, output velocity, input ready);
  modport sink   (input valid, input step_pulse, input direction,
                  input step_count, input velocity, output ready);
endinterface

interface stp_cfg_if;
  import stp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/stp_cfg_regs.sv @@
// Configuration register bank of the stepper controller.
// Depends on stp_pkg for the register codes, reset values and cfg_t.
module stp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_valid,
  output logic                           wr_ready,
  input  logic [stp_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [stp_pkg::CFG_DATA_W-1:0] wr_data,
  output stp_pkg::cfg_t                  cfg
);
  import stp_pkg::*;

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steps_per_rev <= SPR_RESET;
      cfg.gain          <= GAIN_RESET;
      cfg.vel_upper     <= UPPER_RESET;
      cfg.vel_lower     <= LOWER_RESET;
    end else if (wr_valid) begin
      case (cfg_reg_t'(wr_index))
        REG_STEPS_PER_REV: cfg.steps_per_rev <= wr_data[SPR_W-1:0];
        REG_GAIN:          cfg.gain          <= wr_data[GAIN_W-1:0];
        REG_VEL_UPPER:     cfg.vel_upper     <= wr_data[LIM_W-1:0];
        REG_VEL_LOWER:     cfg.vel_lower     <= wr_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/stp_ctrl.sv @@
// Sequencing state machine of the stepper controller: steps the datapath
// through one item and owns the input and result handshakes. Uses stp_pkg.
module stp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output stp_pkg::ctrl_cmd_t cmd,
  input  stp_pkg::dp_stat_t  stat
);
  import stp_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.mul_sel = MUL_K;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_MUL_K;
        end
      end
      ST_MUL_K: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_K;
        state_next  = ST_MUL_NUM;
      end
      ST_MUL_NUM: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_NUM;
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.err_en = 1'b1;
        state_next = ST_MUL_VEL;
      end
      ST_MUL_VEL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_VEL;
        state_next  = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp_en = 1'b1;
        state_next   = ST_MUL_TIME;
      end
      ST_MUL_TIME: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TIME;
        state_next  = ST_COMMIT;
      end
      ST_COMMIT: begin
        // The result register must be free, or be emptied in this cycle.
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

@@ rtl/stp_dpath.sv @@
// Datapath of the stepper controller: shared multiplier, constant divider,
// clamp, step test and the position state. Uses stp_pkg.
module stp_dpath #(
  parameter int ANGLE_FRAC_BITS = stp_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int TIME_BITS       = stp_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  stp_pkg::cfg_t                     cfg,
  input  stp_pkg::ctrl_cmd_t                cmd,
  output stp_pkg::dp_stat_t                 stat,
  input  logic signed [stp_pkg::ANGLE_W-1:0] target_angle,
  input  logic [stp_pkg::TIME_IN_W-1:0]     now_us,
  output logic                              step_pulse,
  output logic                              direction,
  output logic signed [stp_pkg::COUNT_W-1:0] step_count,
  output logic signed [stp_pkg::VEL_W-1:0]  velocity
);
  import stp_pkg::*;

  // Dividend is the 64-bit product with the angle fraction bits dropped.
  localparam int NW   = 64 - ANGLE_FRAC_BITS;
  localparam int NIT  = (NW + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int NWP  = NIT * DIV_STEP_BITS;
  localparam int CW   = (NIT > 1) ? $clog2(NIT) : 1;
  localparam int EW   = (TIME_BITS > TIME_IN_W) ? TIME_BITS : TIME_IN_W;
  localparam logic [NWP-1:0] Q_POS_MAX = NWP'(32'h7FFF_FFFF);
  localparam logic [NWP-1:0] Q_NEG_MAX = NWP'(32'h8000_0000);

  // Item registers.
  logic                      angle_neg;
  logic [ANGLE_W-1:0]        mag;
  logic [TIME_BITS-1:0]      now_r;
  logic signed [MUL_P_W-1:0] prod;
  logic [NWP-1:0]            dq;
  logic [DIV_REM_W-1:0]      rem;
  logic [CW-1:0]             cnt;
  logic signed [ERR_W-1:0]   err;
  logic signed [VEL_W-1:0]   vel;
  logic [TIME_IN_W-1:0]      el_lo;
  logic                      el_big;

  // Controller state kept across items.
  logic signed [COUNT_W-1:0] pos;
  logic [TIME_BITS-1:0]      last;
  logic                      pulse_high;
  logic                      out_dir;
  logic signed [VEL_W-1:0]   out_vel;

  // Combinational terms.
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic [ANGLE_W-1:0]        mag_in;
  logic [NWP-1:0]            dq_n;
  logic [DIV_REM_W-1:0]      rem_n;
  logic [DIV_REM_W:0]        div_t;
  logic [ERR_W-1:0]          tmag;
  logic signed [ERR_W-1:0]   target;
  logic signed [VF_W-1:0]    vfull;
  logic signed [VF_W-1:0]    hi_lim;
  logic signed [VF_W-1:0]    lo_lim;
  logic signed [VF_W-1:0]    vc1;
  logic signed [VF_W-1:0]    vc2;
  logic signed [LIM_W-1:0]   vu;
  logic signed [LIM_W-1:0]   vl;
  logic [VEL_W-1:0]          avel;
  logic [TIME_BITS-1:0]      el;
  logic [EW-1:0]             el_ext;
  logic                      fire;

  assign mag_in = target_angle[ANGLE_W-1] ? ANGLE_W'(-target_angle)
                                          : ANGLE_W'(target_angle);
  assign avel   = vel[VEL_W-1] ? VEL_W'(-vel) : VEL_W'(vel);

  always_comb begin
    case (cmd.mul_sel)
      MUL_K: begin
        mul_a = MUL_W'(cfg.steps_per_rev);
        mul_b = MUL_W'(TWO_PI_DEN);
      end
      MUL_NUM: begin
        mul_a = MUL_W'(mag);
        mul_b = MUL_W'(prod[31:0]);
      end
      MUL_VEL: begin
        mul_a = MUL_W'(cfg.gain);
        mul_b = MUL_W'(err);
      end
      MUL_TIME: begin
        mul_a = MUL_W'(el_lo);
        mul_b = MUL_W'(avel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Restoring division by the constant 2*pi numerator, several bits a cycle.
  // The partial remainder stays below the divisor, so each step is narrow.
  always_comb begin
    dq_n  = dq;
    rem_n = rem;
    div_t = '0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      div_t = {rem_n, dq_n[NWP-1]};
      if (div_t >= TWO_PI_NUM) begin
        rem_n = DIV_REM_W'(div_t - TWO_PI_NUM);
        dq_n  = {dq_n[NWP-2:0], 1'b1};
      end else begin
        rem_n = div_t[DIV_REM_W-1:0];
        dq_n  = {dq_n[NWP-2:0], 1'b0};
      end
    end
  end

  assign stat.div_last = (cnt == CW'(NIT - 1));

  // Quotient to a saturated signed step target, then the error.
  always_comb begin
    if (angle_neg) begin
      tmag = (dq > Q_NEG_MAX) ? ERR_W'(Q_NEG_MAX) : ERR_W'(dq[31:0]);
    end else begin
      tmag = (dq > Q_POS_MAX) ? ERR_W'(Q_POS_MAX) : ERR_W'(dq[31:0]);
    end
    target = angle_neg ? -$signed(tmag) : $signed(tmag);
  end

  // Clamp: the upper limit first, then the lower, so crossed limits give lower.
  assign vu     = cfg.vel_upper;
  assign vl     = cfg.vel_lower;
  assign hi_lim = VF_W'(vu) <<< 8;
  assign lo_lim = VF_W'(vl) <<< 8;
  assign vfull  = prod[VF_W-1:0];
  assign vc1    = (vfull > hi_lim) ? hi_lim : vfull;
  assign vc2    = (vc1 < lo_lim) ? lo_lim : vc1;

  assign el     = now_r - last;
  assign el_ext = EW'(el);

  assign fire = (vel != '0) &&
                (el_big || ($unsigned(prod) > MUL_P_W'(STEP_THRESHOLD)));

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      angle_neg <= target_angle[ANGLE_W-1];
      mag       <= mag_in;
      now_r     <= TIME_BITS'(now_us);
    end
    if (cmd.mul_en) begin
      prod <= mul_p;
    end
    if (cmd.div_load) begin
      dq  <= NWP'(mul_p[63:ANGLE_FRAC_BITS]);
      rem <= '0;
    end else if (cmd.div_step) begin
      dq  <= dq_n;
      rem <= rem_n;
    end
    if (cmd.err_en) begin
      err <= target - ERR_W'(pos);
    end
    if (cmd.clamp_en) begin
      vel    <= vc2[VEL_W-1:0];
      el_lo  <= el_ext[TIME_IN_W-1:0];
      el_big <= (el_ext >> TIME_IN_W) != '0;
    end
    if (cmd.commit) begin
      out_dir <= vel[VEL_W-1];
      out_vel <= vel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      pos        <= '0;
      last       <= '0;
      pulse_high <= 1'b0;
    end else begin
      if (cmd.div_load) begin
        cnt <= '0;
      end else if (cmd.div_step) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.commit) begin
        // The old pulse falls on every call; a new one rises when a step is due.
        pulse_high <= fire;
        if (fire) begin
          last <= now_r;
          if (!vel[VEL_W-1] && pos != COUNT_MAX) begin
            pos <= pos + 1'b1;
          end else if (vel[VEL_W-1] && pos != COUNT_MIN) begin
            pos <= pos - 1'b1;
          end
        end
      end
    end
  end

  assign step_pulse = pulse_high;
  assign direction  = out_dir;
  assign step_count = pos;
  assign velocity   = out_vel;

endmodule

@@ rtl/stepper_p_position_stepper.sv @@
// Stepper position controller: one result for each accepted item, produced after
// the states MUL_K, MUL_NUM, DIV (the angle-to-steps divider), ERR, MUL_VEL,
// CLAMP, MUL_TIME and COMMIT in that order.
// One item at a time: a new item is taken only in the idle state.
// A finished result waits in an output register while the next item is taken.
// Synchronous reset: step count, last step time and pulse clear, limits reload.
module stepper_p_position_stepper #(
  parameter int ANGLE_FRAC_BITS = stp_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int TIME_BITS       = stp_pkg::TIME_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  stp_cfg_if.sink   cfg,
  stp_in_if.sink    req,
  stp_out_if.source rsp
);
  import stp_pkg::*;

  cfg_t      cfg_q;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  stp_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_ready (cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  stp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  stp_dpath #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .TIME_BITS       (TIME_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg_q),
    .cmd          (cmd),
    .stat         (stat),
    .target_angle (req.target_angle),
    .now_us       (req.now_us),
    .step_pulse   (rsp.step_pulse),
    .direction    (rsp.direction),
    .step_count   (rsp.step_count),
    .velocity     (rsp.velocity)
  );

endmodule

@@ rtl/stp_checker.sv @@
// Port-level checks on the result channel of the stepper controller, bound
// to the top level. Uses stp_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module stp_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               step_pulse,
  input logic                               direction,
  input logic signed [stp_pkg::COUNT_W-1:0] step_count,
  input logic signed [stp_pkg::VEL_W-1:0]   velocity
);
  import stp_pkg::*;

  // A stalled beat stays offered.
  `STP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // A stalled beat keeps its payload.
  `STP_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(step_count) && $stable(velocity) && $stable(step_pulse) && $stable(direction))

  // A step is only issued with a nonzero commanded velocity.
  `STP_ASSERT_NOW(a_pulse_vel, clk, rst, out_valid && step_pulse, velocity != '0)

  // Direction reports the sign of the commanded velocity.
  `STP_ASSERT_NOW(a_dir_sign, clk, rst, out_valid, direction == velocity[VEL_W-1])

endmodule

bind stepper_p_position_stepper stp_checker u_stp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .step_pulse (rsp.step_pulse),
  .direction  (rsp.direction),
  .step_count (rsp.step_count),
  .velocity   (rsp.velocity)
);
